/* rtl/dhte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhte_pkg
// Shared types and codes of the double hash table engine.
// ----------------------------------------------------------------------------
package dhte_pkg;

	// request opcodes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// result status codes
	localparam logic [2:0] RS_INSERTED = 3'd0;
	localparam logic [2:0] RS_PRESENT  = 3'd1;
	localparam logic [2:0] RS_FULL     = 3'd2;
	localparam logic [2:0] RS_FOUND    = 3'd3;
	localparam logic [2:0] RS_MISSING  = 3'd4;
	localparam logic [2:0] RS_REMOVED  = 3'd5;

	// slot states
	localparam logic [1:0] SL_EMPTY = 2'd0;
	localparam logic [1:0] SL_USED  = 2'd1;
	localparam logic [1:0] SL_GRAVE = 2'd2;

	// hash seeds
	localparam logic [31:0] SEED_PRI = 32'd1;
	localparam logic [31:0] SEED_SEC = 32'd3;
	localparam logic [31:0] HASH_INIT = 32'hdeadbeef;

	// slot index bits carried in a queued request (covers the largest table)
	localparam int HASH_BITS = 16;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [1:0]           op;
		logic [63:0]          key;
		logic [31:0]          pay;
		logic [HASH_BITS-1:0] h0;
		logic [HASH_BITS-1:0] h1;
	} req_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_PROBE,
		B_EVAL,
		B_MOVE,
		B_DONE
	} back_state_t;

endpackage

/* rtl/dhte_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhte_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dhte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/dhte_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhte_fifo
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module dhte_fifo import dhte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t wdata,
	output logic full,
	input  logic pop,
	output logic empty,
	output req_t rdata
);

	localparam int PW = $clog2(QDEPTH);

	req_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

/* rtl/dhte_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhte_front
// Takes request words, masks them and runs the key hash one mix step a cycle.
// ----------------------------------------------------------------------------
module dhte_front import dhte_pkg::*; #(
	parameter int KEY_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [63:0] key,
	input  logic [31:0] payload,
	input  logic        busy,
	output logic        push,
	output req_t        req,
	input  logic        full
);

	localparam int KW = KEY_BYTES * 8;
	localparam logic [63:0] KMASK = (KW == 64) ? {64{1'b1}} : ((64'd1 << KW) - 64'd1);
	localparam logic [2:0] LAST_STEP = 3'd6;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
		rotl = (x << r) | (x >> (32 - r));
	endfunction

	front_state_t state_q, state_d;
	logic [31:0]  a_q, b_q, c_q;
	logic [31:0]  a_d, b_d, c_d;
	logic [2:0]   step_q;
	logic [1:0]   op_q;
	logic [63:0]  key_q;
	logic [31:0]  pay_q;
	logic [63:0]  key_m;
	logic [31:0]  seed;
	logic         take;

	assign key_m = key & KMASK;
	assign seed  = HASH_INIT + 32'(KEY_BYTES) + SEED_PRI;

	// one mix step of the final lookup3 round
	always_comb begin
		a_d = a_q;
		b_d = b_q;
		c_d = c_q;
		case (step_q)
			3'd0: c_d = (c_q ^ b_q) - rotl(b_q, 14);
			3'd1: a_d = (a_q ^ c_q) - rotl(c_q, 11);
			3'd2: b_d = (b_q ^ a_q) - rotl(a_q, 25);
			3'd3: c_d = (c_q ^ b_q) - rotl(b_q, 16);
			3'd4: a_d = (a_q ^ c_q) - rotl(c_q, 4);
			3'd5: b_d = (b_q ^ a_q) - rotl(a_q, 14);
			3'd6: c_d = (c_q ^ b_q) - rotl(b_q, 24);
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (in_valid && !busy) state_d = F_HASH;
			F_HASH: if (step_q == LAST_STEP) state_d = F_PUSH;
			F_PUSH: if (!full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		push     = 1'b0;
		unique case (state_q)
			F_IDLE: in_stall = busy;
			F_HASH: ;
			F_PUSH: push = !full;
			default: ;
		endcase
	end

	assign take = in_valid && !in_stall;

	assign req.op  = op_q;
	assign req.key = key_q;
	assign req.pay = pay_q;
	assign req.h0  = c_q[HASH_BITS-1:0];
	assign req.h1  = b_q[HASH_BITS-1:0] | HASH_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q   <= opcode;
			key_q  <= key_m;
			pay_q  <= payload;
			a_q    <= seed + key_m[31:0];
			b_q    <= seed + key_m[63:32];
			c_q    <= seed + SEED_SEC;
			step_q <= '0;
		end else if (state_q == F_HASH) begin
			a_q    <= a_d;
			b_q    <= b_d;
			c_q    <= c_d;
			step_q <= step_q + 3'd1;
		end
	end

endmodule

/* rtl/dhte_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhte_back
// Probe sequencer over the slot stores, with result output register.
// ----------------------------------------------------------------------------
module dhte_back import dhte_pkg::*; #(
	parameter int TABLE_SIZE   = 1024,
	parameter int KEY_BYTES    = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  req_t        req,
	output logic        q_pop,
	output logic        clearing,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] value_out
);

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int CW = AW + 1;
	localparam int KW = KEY_BYTES * 8;
	localparam int PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
	localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

	back_state_t   state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [31:0]   value_q;

	logic [1:0]    op_q;
	logic [KW-1:0] key_q;
	logic [PW-1:0] pay_q;
	logic [AW-1:0] h0_q, h1_q, n_q, grave_q;
	logic          have_q;
	logic [2:0]    res_st_q;
	logic [PW-1:0] res_val_q;

	logic [1:0]    st_rd;
	logic [KW-1:0] key_rd;
	logic [PW-1:0] pay_rd;
	logic          hit;

	logic          st_we, kv_we;
	logic [AW-1:0] st_wa, kv_wa;
	logic [1:0]    st_wd;
	logic [KW-1:0] kv_key;
	logic [PW-1:0] kv_pay;

	logic          fin, cont, grab, mv, ins, rem, take_val;
	logic [2:0]    fst;
	logic          start_full, start_bad, deliver;

	dhte_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_st (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(h0_q), .rdata(st_rd)
	);
	dhte_ram #(.WIDTH(KW), .DEPTH(TABLE_SIZE)) u_key (
		.clk(clk), .we(kv_we), .waddr(kv_wa), .wdata(kv_key), .raddr(h0_q), .rdata(key_rd)
	);
	dhte_ram #(.WIDTH(PW), .DEPTH(TABLE_SIZE)) u_pay (
		.clk(clk), .we(kv_we), .waddr(kv_wa), .wdata(kv_pay), .raddr(h0_q), .rdata(pay_rd)
	);

	assign hit        = (key_rd == key_q);
	assign start_full = (req.op == OP_INSERT) && (cnt_q >= CW'(TABLE_SIZE - 1));
	assign start_bad  = (req.op != OP_INSERT) && (req.op != OP_LOOKUP) && (req.op != OP_REMOVE);
	assign deliver    = (state_q == B_DONE) && (!out_valid_q || !out_stall);

	// probe decision on the slot just read
	always_comb begin
		fin = 1'b0; cont = 1'b0; grab = 1'b0; mv = 1'b0;
		ins = 1'b0; rem = 1'b0; take_val = 1'b0; fst = RS_MISSING;
		case (op_q)
			OP_INSERT: begin
				if (st_rd != SL_USED) begin
					ins = 1'b1; fin = 1'b1; fst = RS_INSERTED;
				end else if (hit) begin
					fin = 1'b1; fst = RS_PRESENT;
				end else begin
					cont = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (st_rd == SL_EMPTY) begin
					fin = 1'b1;
				end else if (st_rd == SL_GRAVE) begin
					cont = 1'b1; grab = !have_q;
				end else if (hit) begin
					fin = 1'b1; fst = RS_FOUND; take_val = 1'b1; mv = have_q;
				end else begin
					cont = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (st_rd == SL_EMPTY) begin
					fin = 1'b1;
				end else if (st_rd == SL_USED && hit) begin
					fin = 1'b1; fst = RS_REMOVED; take_val = 1'b1; rem = 1'b1;
				end else begin
					cont = 1'b1;
				end
			end
			default: fin = 1'b1;
		endcase
		// probe bound reached
		if (cont && n_q == LAST) begin
			cont = 1'b0;
			fin  = 1'b1;
			fst  = (op_q == OP_INSERT) ? RS_FULL : RS_MISSING;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR: if (clr_q == LAST) state_d = B_IDLE;
			B_IDLE:  if (!q_empty) state_d = (start_full || start_bad) ? B_DONE : B_PROBE;
			B_PROBE: state_d = B_EVAL;
			B_EVAL:  state_d = mv ? B_MOVE : (fin ? B_DONE : B_PROBE);
			B_MOVE:  state_d = B_DONE;
			B_DONE:  if (!out_valid_q || !out_stall) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		st_we = 1'b0; st_wa = h0_q; st_wd = SL_USED;
		kv_we = 1'b0; kv_wa = h0_q; kv_key = key_q; kv_pay = pay_q;
		q_pop = 1'b0; clearing = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				clearing = 1'b1;
				st_we = 1'b1; st_wa = clr_q; st_wd = SL_EMPTY;
			end
			B_IDLE: q_pop = !q_empty;
			B_PROBE: ;
			B_EVAL: begin
				if (ins) begin
					st_we = 1'b1; kv_we = 1'b1;
				end
				if (mv) begin
					st_we = 1'b1; st_wa = grave_q;
					kv_we = 1'b1; kv_wa = grave_q; kv_pay = pay_rd;
				end
				if (rem) begin
					st_we = 1'b1; st_wd = SL_GRAVE;
				end
			end
			B_MOVE: begin
				st_we = 1'b1; st_wd = SL_GRAVE;
			end
			B_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == B_EVAL) begin
				if (ins) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (rem && cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q      <= req.op;
			key_q     <= req.key[KW-1:0];
			pay_q     <= req.pay[PW-1:0];
			h0_q      <= req.h0[AW-1:0];
			h1_q      <= req.h1[AW-1:0];
			n_q       <= '0;
			have_q    <= 1'b0;
			res_val_q <= '0;
			res_st_q  <= start_full ? RS_FULL : RS_MISSING;
		end else if (state_q == B_EVAL) begin
			if (grab) begin
				have_q  <= 1'b1;
				grave_q <= h0_q;
			end
			if (cont) begin
				h0_q <= h0_q + h1_q;
				n_q  <= n_q + 1'b1;
			end
			if (fin) begin
				res_st_q <= fst;
			end
			if (take_val) begin
				res_val_q <= pay_rd;
			end
		end
		if (deliver) begin
			status_q <= res_st_q;
			value_q  <= 32'(res_val_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value_out = value_q;

endmodule

/* rtl/double_hash_table_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_table_engine
// Open-addressed hash table with double hashing: insert, lookup, remove.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          word
//  -------  ---  -----------------  -------------------------
//  in       in   in_valid/in_stall  opcode, key, payload
//  out      out  out_valid/out_stall status, value_out
//
// The front takes no new word until the last one is pushed: capture, seven
// hash mix steps, then a push into the two-entry queue, held while it is full.
// For each probed slot the back runs a registered RAM read, then the
// decision; each request adds a queue pop and a result hand-off, and a
// lookup that relocates an entry into a tombstone adds a move state for the
// second status write.
// After reset the slot status RAM is swept to empty, one slot per cycle,
// over all TABLE_SIZE slots; in_stall stays high during the sweep.
// A stalled result sits in the output register while the front and the
// queue keep taking new words until the queue is full.
// ----------------------------------------------------------------------------
module double_hash_table_engine import dhte_pkg::*; #(
	parameter int TABLE_SIZE   = 1024,
	parameter int KEY_BYTES    = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [63:0] key,
	input  logic [31:0] payload,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] value_out
);

	// front to queue
	logic push;
	logic full;
	req_t req_in;

	// queue to back
	logic q_empty;
	logic q_pop;
	req_t req_out;

	// back holds the front off during the clearing sweep
	logic clearing;

	dhte_front #(.KEY_BYTES(KEY_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .key(key), .payload(payload),
		.busy(clearing), .push(push), .req(req_in), .full(full)
	);

	dhte_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(req_in), .full(full),
		.pop(q_pop), .empty(q_empty), .rdata(req_out)
	);

	dhte_back #(
		.TABLE_SIZE(TABLE_SIZE), .KEY_BYTES(KEY_BYTES), .PAYLOAD_BITS(PAYLOAD_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .req(req_out), .q_pop(q_pop), .clearing(clearing),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .value_out(value_out)
	);

endmodule

/* rtl/dhte_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhte_checker
// Port-level checks on the result channel of the engine.
// ----------------------------------------------------------------------------
module dhte_checker import dhte_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [31:0] value_out
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(value_out))
		else $error("stalled result word changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= RS_REMOVED)
		else $error("status code out of range");

	a_zero_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == RS_INSERTED || status == RS_PRESENT ||
			status == RS_FULL || status == RS_MISSING) |-> value_out == 32'd0)
		else $error("value given without a hit");

endmodule

bind double_hash_table_engine dhte_checker u_chk (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the double hash table engine against a predictor of its table:
// lookup3 hash pair, probe walk with tombstones, relocation on lookup hits.
// ----------------------------------------------------------------------------
module testbench;
	import dhte_pkg::*;

	localparam int SLOTS = 1024;
	localparam int LIMIT_CYCLES = 2000000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [63:0] key;
	logic [31:0] payload;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [31:0] value_out;

	double_hash_table_engine DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .key(key), .payload(payload),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .value_out(value_out)
	);

	// predicted table contents
	logic [1:0]  tbl_state [SLOTS];
	logic [63:0] tbl_key   [SLOTS];
	logic [31:0] tbl_pay   [SLOTS];
	int unsigned tbl_count;

	// results still owed by the block, oldest first
	logic [2:0]  owed_status [$];
	logic [31:0] owed_value  [$];

	int  errors;
	int  cycles;
	bit  hold_off;          // long receiver hold-off requested
	bit  stall_random;      // random stall pattern enabled
	logic [63:0] known_keys [$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] rotl(logic [31:0] x, int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	// lookup3 pair for an 8-byte key, seeds 1 and 3
	function automatic void hash_key(input logic [63:0] k,
			output logic [31:0] h0, output logic [31:0] h1);
		logic [31:0] a, b, c;
		a = HASH_INIT + 32'd8 + SEED_PRI;
		b = a;
		c = a + SEED_SEC;
		a += k[31:0];
		b += k[63:32];
		c ^= b; c -= rotl(b, 14);
		a ^= c; a -= rotl(c, 11);
		b ^= a; b -= rotl(a, 25);
		c ^= b; c -= rotl(b, 16);
		a ^= c; a -= rotl(c, 4);
		b ^= a; b -= rotl(a, 14);
		c ^= b; c -= rotl(b, 24);
		h0 = c;
		h1 = b | 32'd1;
	endfunction

	// apply one request to the predicted table and return its result
	function automatic void table_apply(input logic [1:0] op, input logic [63:0] k,
			input logic [31:0] p, output logic [2:0] rs, output logic [31:0] rv);
		logic [31:0] h0, h1;
		int idx, grave;
		bit have_grave;
		rs = RS_MISSING;
		rv = '0;
		have_grave = 0;
		grave = 0;
		hash_key(k, h0, h1);
		if (op == OP_INSERT) begin
			rs = RS_FULL;
			if (tbl_count < SLOTS - 1) begin
				for (int n = 0; n < SLOTS; n++) begin
					idx = h0 % SLOTS;
					if (tbl_state[idx] != SL_USED) begin
						tbl_state[idx] = SL_USED;
						tbl_key[idx] = k;
						tbl_pay[idx] = p;
						tbl_count++;
						rs = RS_INSERTED;
						break;
					end
					if (tbl_key[idx] == k) begin
						rs = RS_PRESENT;
						break;
					end
					h0 += h1;
				end
			end
		end else if (op == OP_LOOKUP) begin
			for (int n = 0; n < SLOTS; n++) begin
				idx = h0 % SLOTS;
				if (tbl_state[idx] == SL_EMPTY) break;
				if (tbl_state[idx] == SL_GRAVE) begin
					if (!have_grave) begin
						have_grave = 1;
						grave = idx;
					end
				end else if (tbl_key[idx] == k) begin
					rv = tbl_pay[idx];
					rs = RS_FOUND;
					// hit moves into the first tombstone passed
					if (have_grave) begin
						tbl_state[grave] = SL_USED;
						tbl_key[grave] = tbl_key[idx];
						tbl_pay[grave] = tbl_pay[idx];
						tbl_state[idx] = SL_GRAVE;
					end
					break;
				end
				h0 += h1;
			end
		end else if (op == OP_REMOVE) begin
			for (int n = 0; n < SLOTS; n++) begin
				idx = h0 % SLOTS;
				if (tbl_state[idx] == SL_EMPTY) break;
				if (tbl_state[idx] == SL_USED && tbl_key[idx] == k) begin
					rv = tbl_pay[idx];
					tbl_state[idx] = SL_GRAVE;
					if (tbl_count > 0) tbl_count--;
					rs = RS_REMOVED;
					break;
				end
				h0 += h1;
			end
		end
	endfunction

	// burst sender: back-to-back words keep valid high across the boundary
	task automatic send_burst_word(input logic [1:0] op, input logic [63:0] k,
			input logic [31:0] p);
		logic [2:0]  rs;
		logic [31:0] rv;
		opcode   <= op;
		key      <= k;
		payload  <= p;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		table_apply(op, k, p, rs, rv);
		owed_status.push_back(rs);
		owed_value.push_back(rv);
		@(negedge clk);
	endtask

	// offer one word, then leave valid low for a cycle
	task automatic send_word(input logic [1:0] op, input logic [63:0] k,
			input logic [31:0] p);
		send_burst_word(op, k, p);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (owed_status.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [63:0] pick_key();
		if (known_keys.size() != 0 && $urandom_range(0, 3) != 0)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return OP_INSERT;
		if (r < 70) return OP_LOOKUP;
		if (r < 98) return OP_REMOVE;
		return OP_UNUSED;  // unused opcode answers not found
	endfunction

	// extremes of the fields, every operation, duplicates, tombstone walk
	task automatic test_directed();
		send_word(OP_LOOKUP, 64'h0, 32'h0);
		send_word(OP_REMOVE, 64'h0, 32'h0);
		send_word(OP_INSERT, 64'h0, 32'h0);
		send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_word(OP_INSERT, 64'h0, 32'h1234_5678);      // duplicate
		send_word(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		send_word(OP_LOOKUP, 64'h0, 32'hFFFF_FFFF);
		send_word(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_word(OP_REMOVE, 64'h0, 32'h0);
		send_word(OP_REMOVE, 64'h0, 32'h0);               // already a tombstone
		send_word(OP_LOOKUP, 64'h0, 32'h0);
		send_word(OP_INSERT, 64'h0, 32'hA5A5_5A5A);       // reuses tombstone
		send_word(OP_INSERT, 64'h5555_5555_5555_5555, 32'h5555_5555);
		send_word(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
		send_word(OP_REMOVE, 64'h5555_5555_5555_5555, 32'h0);
		send_word(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0);
		send_word(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		send_word(OP_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0);
		send_word(OP_REMOVE, 64'h0, 32'h0);
		drain();
	endtask

	// random mix over a small key pool so hits, tombstones and moves occur
	task automatic test_random_mix(input int words);
		int left;
		known_keys.delete();
		for (int i = 0; i < 48; i++) known_keys.push_back({$urandom(), $urandom()});
		left = words;
		while (left > 0) begin
			int burst;
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && left > 0; i++, left--)
				send_burst_word(pick_op(), pick_key(), $urandom());
			in_valid <= 1'b0;
			@(negedge clk);
			if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(negedge clk);
		end
		in_valid <= 1'b0;
		drain();
	endtask

	// receiver holds off long while the sender keeps offering words
	task automatic test_back_pressure();
		hold_off = 1'b1;
		for (int i = 0; i < 40; i++)
			send_burst_word(pick_op(), pick_key(), $urandom());
		in_valid <= 1'b0;
		drain();
	endtask

	// fill the table to the count limit, then refuse, then thin it out again
	task automatic test_fill_to_full();
		logic [63:0] fill_keys [$];
		logic [63:0] k;
		stall_random = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			k = {$urandom(), $urandom()};
			fill_keys.push_back(k);
			send_burst_word(OP_INSERT, k, $urandom());
		end
		send_burst_word(OP_INSERT, 64'h0123_4567_89AB_CDEF, 32'h0);
		send_burst_word(OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'h0);
		in_valid <= 1'b0;
		drain();
		stall_random = 1'b1;
		foreach (fill_keys[i])
			if (i % 2 == 0) send_burst_word(OP_REMOVE, fill_keys[i], 32'h0);
		in_valid <= 1'b0;
		drain();
	endtask

	// receiver stall pattern: random, with clear stretches and one long hold-off
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				hold = 0;
				while (hold < 400) begin
					@(negedge clk);
					hold++;
				end
				out_stall <= 1'b0;
				hold_off = 1'b0;
			end else if (stall_random && (cycles / 500) % 4 != 3) begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (owed_status.size() == 0) begin
				$display("%0t: unexpected result status=%0d value=%h",
					$realtime, status, value_out);
				errors++;
			end else begin
				if (status !== owed_status[0]) begin
					$display("%0t: status expected %0d actual %0d",
						$realtime, owed_status[0], status);
					errors++;
				end
				if (value_out !== owed_value[0]) begin
					$display("%0t: value_out expected %h actual %h",
						$realtime, owed_value[0], value_out);
					errors++;
				end
				void'(owed_status.pop_front());
				void'(owed_value.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		hold_off = 1'b0;
		stall_random = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_INSERT;
		key = '0;
		payload = '0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_state[i] = SL_EMPTY;
			tbl_key[i] = '0;
			tbl_pay[i] = '0;
		end
		tbl_count = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_back_pressure();
		test_random_mix(400);
		test_fill_to_full();

		if (owed_status.size() != 0) begin
			$display("%0t: %0d results never arrived", $realtime, owed_status.size());
			errors++;
		end
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
